FILE: hw/rtl/bfc_pkg.sv
package bfc_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned VAL_W           = 32;

    localparam logic [2:0] OP_ROW_W = 3'd3;
    localparam logic [2:0] OP_TEST  = 3'd4;

    localparam logic [1:0] CULL_KEEP  = 2'd0;
    localparam logic [1:0] CULL_SET   = 2'd1;
    localparam logic [1:0] CULL_CLEAR = 2'd2;

    localparam logic [5:0] OC_Y_BELOW = 6'h08;
    localparam logic [5:0] OC_Y_ABOVE = 6'h04;
    localparam logic [5:0] OC_Z_FAR   = 6'h20;
    localparam logic [5:0] OC_Z_NEAR  = 6'h10;
    localparam logic [5:0] OC_X_LEFT  = 6'h02;
    localparam logic [5:0] OC_X_RIGHT = 6'h01;
    localparam logic [5:0] OC_ALL     = 6'h3F;
    localparam logic [5:0] OC_NONE    = 6'h00;

    // 8 corners x 4 rows x 4 steps, plus a final store step and a final evaluate step
    localparam int unsigned SEQ_LAST = 129;
    localparam int unsigned CNT_W    = $clog2(SEQ_LAST + 1);

    typedef struct packed {
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;

endpackage

FILE: hw/rtl/bfc_mac.sv
module bfc_mac #(
    parameter int unsigned COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = bfc_pkg::FRAC_BITS_DEF,
    parameter int unsigned OPW         = bfc_pkg::VAL_W
) (
    input  logic                          i_clk,
    input  bfc_pkg::t_mac_ctl             i_ctl,
    input  logic signed [OPW-1:0]         i_coef,
    input  logic signed [OPW-1:0]         i_coord,
    output logic signed [COORD_WIDTH-1:0] o_sum
);

    localparam int unsigned PW    = 2 * OPW - FRAC_BITS;
    localparam int unsigned WIDE  = ((PW > OPW) ? PW : OPW) + 2;
    localparam int unsigned ACC_W = (WIDE > COORD_WIDTH) ? WIDE : COORD_WIDTH;
    localparam logic signed [ACC_W-1:0] HMAX =
        ACC_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] HMIN = -HMAX - ACC_W'(1);

    logic signed [2*OPW-1:0] mul;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] sum;

    assign mul = i_coef * i_coord;
    assign sum = r_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        // floored product
        r_prod <= mul[2*OPW-1:FRAC_BITS];
        if (i_ctl.acc_load) begin
            r_acc <= ACC_W'(i_coef);
        end else if (i_ctl.acc_add) begin
            r_acc <= sum;
        end
    end

    always_comb begin
        if (sum > HMAX) begin
            o_sum = HMAX[COORD_WIDTH-1:0];
        end else if (sum < HMIN) begin
            o_sum = HMIN[COORD_WIDTH-1:0];
        end else begin
            o_sum = sum[COORD_WIDTH-1:0];
        end
    end

endmodule

FILE: hw/rtl/bbox_frustum_cull_test_top.sv
// Frustum cull test for an axis-aligned box against a 4x4 local-to-clip matrix
// in signed fixed point. Opcodes 0..3 load one matrix row and give no result;
// opcodes 5..7 are dropped. A test item whose flags skip the frustum test
// gives its result in the cycle after acceptance. A full test evaluates the
// four matrix rows at all eight corners on a single shared multiply-accumulate
// unit, one coefficient product per cycle, then loads the output register once
// the output side is free. The input side is not ready while a test runs or
// while a finished result is still waiting to be taken.
module bbox_frustum_cull_test_top #(
    parameter int unsigned COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = bfc_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic signed [31:0] i_val_a,
    input  logic signed [31:0] i_val_b,
    input  logic signed [31:0] i_val_c,
    input  logic signed [31:0] i_val_d,
    input  logic signed [31:0] i_val_e,
    input  logic signed [31:0] i_val_f,
    input  logic        i_is_hidden,
    input  logic        i_always_test,
    input  logic        i_never_cull,
    input  logic        i_has_geometry,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_cull_action,
    output logic        o_fully_inside,
    output logic [5:0]  o_outcode_and,
    output logic [5:0]  o_outcode_or
);

    localparam int unsigned OPW = (COORD_WIDTH < bfc_pkg::VAL_W) ? COORD_WIDTH : bfc_pkg::VAL_W;
    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned CNT_W = bfc_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]     r_cnt;
    logic signed [OPW-1:0] r_mat [4][4];
    logic signed [OPW-1:0] r_box [6];
    logic signed [CW-1:0]  r_hx;
    logic signed [CW-1:0]  r_hy;
    logic signed [CW-1:0]  r_hz;
    logic signed [CW-1:0]  r_hw;
    logic [5:0]            r_and;
    logic [5:0]            r_or;
    logic                  r_out_valid;
    logic [1:0]            r_cull_action;
    logic                  r_fully_inside;
    logic [5:0]            r_outcode_and;
    logic [5:0]            r_outcode_or;

    logic                  in_xfer;
    logic                  is_load;
    logic                  is_test;
    logic                  run_test;
    logic                  out_free;
    logic                  fin_write;
    logic                  running;
    logic [1:0]            step;
    logic [1:0]            row;
    logic [2:0]            corner;
    logic [1:0]            term;
    logic                  store;
    logic [1:0]            store_row;
    logic                  eval;
    logic signed [OPW-1:0] coef;
    logic signed [OPW-1:0] coord;
    logic signed [CW-1:0]  h_sum;
    bfc_pkg::t_mac_ctl     mac_ctl;
    logic signed [CW:0]    hx_e;
    logic signed [CW:0]    hy_e;
    logic signed [CW:0]    hz_e;
    logic signed [CW:0]    hw_e;
    logic signed [CW:0]    nw_e;
    logic [5:0]            code;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign is_load    = i_opcode <= bfc_pkg::OP_ROW_W;
    assign is_test    = i_opcode == bfc_pkg::OP_TEST;
    assign run_test   = i_always_test || (!i_is_hidden && i_has_geometry && !i_never_cull);
    assign fin_write  = (r_state == S_FIN) && out_free;

    assign running   = r_state == S_RUN;
    assign step      = r_cnt[1:0];
    assign row       = r_cnt[3:2];
    assign corner    = r_cnt[6:4];
    // step 0 reads the translation term, steps 1..3 the coefficients
    assign term      = step - 2'd1;
    assign store     = running && (step == 2'd0) && (r_cnt != '0);
    assign store_row = row - 2'd1;
    assign eval      = running && (r_cnt[3:0] == 4'd1) && (r_cnt[CNT_W-1:4] != '0);

    assign mac_ctl.acc_load = running && (step == 2'd0);
    assign mac_ctl.acc_add  = running && step[1];

    assign coef = r_mat[row][term];

    always_comb begin
        case (term)
            2'd0:    coord = corner[2] ? r_box[3] : r_box[0];
            2'd1:    coord = corner[1] ? r_box[4] : r_box[1];
            2'd2:    coord = corner[0] ? r_box[5] : r_box[2];
            default: coord = r_box[0];
        endcase
    end

    bfc_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .OPW         (OPW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctl   (mac_ctl),
        .i_coef  (coef),
        .i_coord (coord),
        .o_sum   (h_sum)
    );

    assign hx_e = (CW+1)'(r_hx);
    assign hy_e = (CW+1)'(r_hy);
    assign hz_e = (CW+1)'(r_hz);
    assign hw_e = (CW+1)'(r_hw);
    assign nw_e = -hw_e;

    always_comb begin
        code = bfc_pkg::OC_NONE;
        if (hy_e < nw_e) begin
            code = code | bfc_pkg::OC_Y_BELOW;
        end else if (hy_e > hw_e) begin
            code = code | bfc_pkg::OC_Y_ABOVE;
        end
        if (hz_e > hw_e) begin
            code = code | bfc_pkg::OC_Z_FAR;
        end else if (hz_e < (CW+1)'(0)) begin
            code = code | bfc_pkg::OC_Z_NEAR;
        end
        if (hx_e < nw_e) begin
            code = code | bfc_pkg::OC_X_LEFT;
        end else if (hx_e > hw_e) begin
            code = code | bfc_pkg::OC_X_RIGHT;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && is_test && run_test) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == CNT_W'(bfc_pkg::SEQ_LAST)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_mat[i][j] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            if (running) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (in_xfer && is_load) begin
                r_mat[i_opcode[1:0]][0] <= i_val_a[OPW-1:0];
                r_mat[i_opcode[1:0]][1] <= i_val_b[OPW-1:0];
                r_mat[i_opcode[1:0]][2] <= i_val_c[OPW-1:0];
                r_mat[i_opcode[1:0]][3] <= i_val_d[OPW-1:0];
            end
            if ((in_xfer && is_test && !run_test) || fin_write) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && is_test) begin
            r_box[0] <= i_val_a[OPW-1:0];
            r_box[1] <= i_val_b[OPW-1:0];
            r_box[2] <= i_val_c[OPW-1:0];
            r_box[3] <= i_val_d[OPW-1:0];
            r_box[4] <= i_val_e[OPW-1:0];
            r_box[5] <= i_val_f[OPW-1:0];
            r_and    <= bfc_pkg::OC_ALL;
            r_or     <= bfc_pkg::OC_NONE;
            if (!run_test) begin
                r_cull_action  <= (!i_is_hidden && i_has_geometry) ?
                                  bfc_pkg::CULL_CLEAR : bfc_pkg::CULL_KEEP;
                r_fully_inside <= 1'b0;
                r_outcode_and  <= bfc_pkg::OC_NONE;
                r_outcode_or   <= bfc_pkg::OC_NONE;
            end
        end
        if (eval) begin
            r_and <= r_and & code;
            r_or  <= r_or | code;
        end
        if (store) begin
            case (store_row)
                2'd0:    r_hx <= h_sum;
                2'd1:    r_hy <= h_sum;
                2'd2:    r_hz <= h_sum;
                default: r_hw <= h_sum;
            endcase
        end
        if (fin_write) begin
            r_cull_action  <= (r_and != bfc_pkg::OC_NONE) ?
                              bfc_pkg::CULL_SET : bfc_pkg::CULL_CLEAR;
            r_fully_inside <= r_or == bfc_pkg::OC_NONE;
            r_outcode_and  <= r_and;
            r_outcode_or   <= r_or;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cull_action  = r_cull_action;
    assign o_fully_inside = r_fully_inside;
    assign o_outcode_and  = r_outcode_and;
    assign o_outcode_or   = r_outcode_or;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= CNT_W'(bfc_pkg::SEQ_LAST)))
        else $error("sequence counter out of range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FIN || $past(r_state) == S_IDLE))
        else $error("result appeared outside idle or finish");

    a_inside_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fully_inside) |->
        (o_outcode_or == bfc_pkg::OC_NONE && o_cull_action == bfc_pkg::CULL_CLEAR))
        else $error("fully inside with outcodes or cull set");

    a_and_in_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_outcode_and & ~o_outcode_or) == bfc_pkg::OC_NONE))
        else $error("outcode and not contained in outcode or");

    a_run_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == CNT_W'(bfc_pkg::SEQ_LAST)) |=> (r_state == S_FIN))
        else $error("test sequence did not finish");
`endif

endmodule
